// File: rtl/core/bnfa_pkg.sv
// Shared constants, codes and controller/datapath interface types for the allocator.
`default_nettype none
package bnfa_pkg;

  localparam int MAP_BYTES_DEF     = 1024;
  localparam int TOTAL_ENTRIES_DEF = 8192;

  localparam int IDX_W    = 14;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_wr;     // write zero at the clear pointer and advance it
    logic load;       // latch the request word
    logic rd;         // read the byte at the byte pointer
    logic scan_adv;   // step the byte pointer, wrapping
    logic alloc_wr;   // set the first free bit, update position, count and result
    logic free_wr;    // clear the bit, bump the count, post ok result
    logic out_full;   // post a no-free-entry result
    logic out_bad;    // post a bad-free result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_done;
    logic req_free;
    logic count_zero;
    logic free_bad;
    logic has_free;
    logic bit_set;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/core/bnfa_ctrl.sv
// Sequencer for clearing, scanning and updating the allocation bitmap.
`default_nettype none
module bnfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  bnfa_pkg::sts_t     sts,
  output bnfa_pkg::cmd_t     cmd
);
  import bnfa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RFULL = 3'd5;
  localparam logic [2:0] S_RBAD  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (!sts.req_free && sts.count_zero) begin
          state_nxt = S_RFULL;
        end else if (sts.req_free && sts.free_bad) begin
          state_nxt = S_RBAD;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.req_free) begin
          if (!sts.bit_set) begin
            state_nxt = S_RBAD;
          end else if (sts.out_free) begin
            cmd.free_wr = 1'b1;
            state_nxt   = S_IDLE;
          end
        end else begin
          if (sts.has_free) begin
            // hold the read byte until the result register can take the word
            if (sts.out_free) begin
              cmd.alloc_wr = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else if (sts.scan_last) begin
            state_nxt = S_RFULL;
          end else begin
            cmd.scan_adv = 1'b1;
            state_nxt    = S_READ;
          end
        end
      end
      S_RFULL: begin
        if (sts.out_free) begin
          cmd.out_full = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RBAD: begin
        if (sts.out_free) begin
          cmd.out_bad = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bnfa_datapath.sv
// Bitmap memory, position and count registers, and result register of the allocator.
`default_nettype none
module bnfa_datapath #(
  parameter int MAP_BYTES     = bnfa_pkg::MAP_BYTES_DEF,
  parameter int TOTAL_ENTRIES = bnfa_pkg::TOTAL_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  bnfa_pkg::cmd_t                     cmd,
  output bnfa_pkg::sts_t                     sts,
  input  wire logic                          in_req,
  input  wire logic [bnfa_pkg::IDX_W-1:0]    in_entry,
  input  wire logic                          cfg_wr_en,
  input  wire logic                          cfg_wr_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bnfa_pkg::IDX_W-1:0]         out_index,
  output logic [bnfa_pkg::STATUS_W-1:0]      out_status
);
  import bnfa_pkg::*;

  localparam int MAP_BITS   = MAP_BYTES * 8;
  localparam int USABLE     = (TOTAL_ENTRIES < MAP_BITS) ? TOTAL_ENTRIES : MAP_BITS;
  localparam int USED_BYTES = (USABLE + 7) / 8;
  localparam int AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int PW         = AW + 3;
  localparam int CW         = $clog2(TOTAL_ENTRIES + 1);
  localparam int LAST_REM   = USABLE - 8 * (USED_BYTES - 1);
  localparam logic [15:0] LAST_SH = 16'hFF00 >> LAST_REM;
  localparam logic [7:0]  LAST_MASK = LAST_SH[7:0];
  localparam logic [AW-1:0] LAST_BYTE = AW'(USED_BYTES - 1);

  // Most significant set bit wins
  function automatic logic [2:0] first_free(input logic [7:0] bits);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) p = 3'(7 - i);
    end
    return p;
  endfunction

  logic [7:0]    mem [MAP_BYTES];
  logic [7:0]    rd_r;
  logic [AW-1:0] clr_ptr_r;
  logic [AW-1:0] byte_r;
  logic [AW-1:0] byte_nxt;
  logic [AW-1:0] scan_r;
  logic [PW-1:0] last_pos_r;
  logic [CW-1:0] cnt_r;
  logic          base_r;
  logic          req_r;
  logic [IDX_W-1:0] raw_r;
  logic [2:0]    fbit_r;
  logic          out_valid_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [31:0]   in_idx;
  logic [31:0]   raw_idx;
  logic [AW-1:0] start_byte;
  logic [7:0]    byte_mask;
  logic [7:0]    free_bits;
  logic [2:0]    pick;
  logic [7:0]    pick_bit;
  logic [7:0]    free_bit;
  logic [PW-1:0] alloc_idx;
  logic [31:0]   alloc_sum;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;

  assign in_idx     = 32'(in_entry) - 32'(base_r);
  assign raw_idx    = 32'(raw_r) - 32'(base_r);
  assign start_byte = (32'(last_pos_r[PW-1:3]) >= 32'(USED_BYTES)) ? '0 : last_pos_r[PW-1:3];
  assign byte_mask  = (byte_r == LAST_BYTE) ? LAST_MASK : 8'hFF;
  assign free_bits  = ~rd_r & byte_mask;
  assign pick       = first_free(free_bits);
  assign pick_bit   = 8'h80 >> pick;
  assign free_bit   = 8'h80 >> fbit_r;
  assign alloc_idx  = {byte_r, pick};
  assign alloc_sum  = 32'(alloc_idx) + 32'(base_r);
  assign byte_nxt   = (byte_r == LAST_BYTE) ? '0 : byte_r + 1'b1;

  assign sts.clr_done   = (clr_ptr_r == LAST_BYTE);
  assign sts.req_free   = (req_r == REQ_FREE);
  assign sts.count_zero = (cnt_r == '0);
  assign sts.free_bad   = (32'(raw_r) < 32'(base_r)) || (raw_idx >= 32'(USABLE));
  assign sts.has_free   = (free_bits != 8'h00);
  assign sts.bit_set    = ((rd_r & free_bit) != 8'h00);
  assign sts.scan_last  = (scan_r == LAST_BYTE);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign mem_we = cmd.clr_wr || cmd.alloc_wr || cmd.free_wr;
  assign mem_wa = cmd.clr_wr ? clr_ptr_r : byte_r;
  always_comb begin
    mem_wd = 8'h00;
    if (cmd.alloc_wr) mem_wd = rd_r | pick_bit;
    else if (cmd.free_wr) mem_wd = rd_r & ~free_bit;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) rd_r <= mem[byte_r];
  end

  // Request and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req;
      raw_r  <= in_entry;
      fbit_r <= in_idx[2:0];
      scan_r <= '0;
      byte_r <= (in_req == REQ_FREE) ? in_idx[AW+2:3] : start_byte;
    end else if (cmd.scan_adv) begin
      byte_r <= byte_nxt;
      scan_r <= scan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r   <= '0;
      last_pos_r  <= '0;
      cnt_r       <= CW'(TOTAL_ENTRIES);
      base_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_ptr_r <= clr_ptr_r + 1'b1;
      if (cfg_wr_en) base_r <= cfg_wr_data;
      if (cmd.alloc_wr) begin
        last_pos_r <= alloc_idx;
        cnt_r      <= cnt_r - 1'b1;
      end else if (cmd.free_wr && (32'(cnt_r) < 32'(TOTAL_ENTRIES))) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.alloc_wr || cmd.free_wr || cmd.out_full || cmd.out_bad) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_wr) begin
      out_index_r  <= alloc_sum[IDX_W-1:0];
      out_status_r <= ST_OK;
    end else if (cmd.free_wr) begin
      out_index_r  <= '0;
      out_status_r <= ST_OK;
    end else if (cmd.out_full) begin
      out_index_r  <= '0;
      out_status_r <= ST_FULL;
    end else if (cmd.out_bad) begin
      out_index_r  <= '0;
      out_status_r <= ST_BAD;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(TOTAL_ENTRIES))
    else $error("free count above total entries");
  a_alloc_has_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |-> (sts.has_free && !sts.count_zero))
    else $error("allocation without a free bit or count");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |->
      !(cmd.alloc_wr || cmd.free_wr || cmd.out_full || cmd.out_bad))
    else $error("result word overwritten while stalled");
  a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_wr |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("free count not decremented on allocation");
`endif

endmodule
`default_nettype wire

// File: rtl/core/bitmap_next_fit_allocator.sv
// Top level of the next-fit bitmap allocator: controller plus datapath.
// From accept to out_tvalid: a free passes S_START, S_READ and S_CHECK; an allocate does one
// memory read and one check per bitmap byte scanned; a fruitless scan reads all USED_BYTES.
// A zero count or an out-of-range free answers from S_START via S_RFULL or S_RBAD, a double free
// from S_CHECK via S_RBAD. One request in work at a time; in_tready is high only in S_IDLE.
// After reset a clearing pass writes every used bitmap byte, one per cycle
// (USED_BYTES of them, 1024 at default sizes); in_tready stays low until it ends.
`default_nettype none
module bitmap_next_fit_allocator #(
  parameter int MAP_BYTES     = bnfa_pkg::MAP_BYTES_DEF,
  parameter int TOTAL_ENTRIES = bnfa_pkg::TOTAL_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [13:0] entry_index, [15:14] zero
  input  wire logic        in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [13:0] alloc_index, [15:14] status
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);
  import bnfa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [IDX_W-1:0]    out_index;
  logic [STATUS_W-1:0] out_status;

  bnfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bnfa_datapath #(
    .MAP_BYTES     (MAP_BYTES),
    .TOTAL_ENTRIES (TOTAL_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req      (in_tuser),
    .in_entry    (in_tdata[IDX_W-1:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_index   (out_index),
    .out_status  (out_status)
  );

  assign out_tdata = {out_status, out_index};

endmodule
`default_nettype wire
